>>> rtl/ctsv_pkg.sv
package ctsv_pkg;

  // file layout
  localparam int unsigned HEADER_BYTES   = 64;
  localparam int unsigned SAMPLE_BYTES   = 32;
  localparam int unsigned SAMPLE_SHIFT   = $clog2(SAMPLE_BYTES);
  localparam int unsigned HDR_WORDS      = 10;
  localparam int unsigned HDR_IDX_W      = $clog2(HDR_WORDS);
  localparam int unsigned HDR_CAPTURE    = HDR_WORDS * 4;
  localparam int unsigned OFFSET_WORD    = 8;
  // byte position inside a sample at which the field of view word is complete
  localparam int unsigned FOV_LAST_POS   = 27;
  localparam int unsigned CHECKED_BYTES  = 32;

  // header expectations
  localparam logic [15:0] VERSION_VAL    = 16'd1;
  localparam logic [31:0] RATE_VAL       = 32'd30;
  localparam logic [31:0] FLAGS_VAL      = 32'd1;
  localparam logic [7:0]  MAGIC [4]      = '{8'h44, 8'h50, 8'h43, 8'h4D};

  // float bit patterns
  localparam logic [31:0] EXP_MASK       = 32'h7F80_0000;
  localparam logic [31:0] FOV_LIMIT      = 32'h4334_0000;

  // crc
  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_HOLE_LO    = 32'd12;
  localparam logic [31:0] CRC_HOLE_HI    = 32'd16;

  localparam logic [31:0] INDEX_MAX      = 32'hFFFF_FFFF;
  localparam logic [23:0] MAX_FRAMES_RST = 24'd65535;

  // result packing
  localparam int unsigned STATUS_W       = 4;
  localparam int unsigned RESULT_BITS    = STATUS_W + 5 * 32;
  localparam int unsigned RESULT_W       = ((RESULT_BITS + 7) / 8) * 8;

  // status codes, lowest failing check wins
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNCATED = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_VERSION   = 4'd3;
  localparam logic [3:0] ST_HDR_SIZE  = 4'd4;
  localparam logic [3:0] ST_TOTAL     = 4'd5;
  localparam logic [3:0] ST_CRC       = 4'd6;
  localparam logic [3:0] ST_RATE      = 4'd7;
  localparam logic [3:0] ST_FRAMES    = 4'd8;
  localparam logic [3:0] ST_COUNT     = 4'd9;
  localparam logic [3:0] ST_STRIDE    = 4'd10;
  localparam logic [3:0] ST_OFFSET    = 4'd11;
  localparam logic [3:0] ST_FLAGS     = 4'd12;
  localparam logic [3:0] ST_NONFINITE = 4'd13;

  // everything the verdict needs, taken on the last byte
  typedef struct packed {
    logic [31:0] size;
    logic [31:0] crc;
    logic        magic_ok;
    logic        sample_bad;
    logic [31:0] version_word;
    logic [31:0] size_field;
    logic [31:0] crc_field;
    logic [31:0] rate;
    logic [31:0] frames;
    logic [31:0] count;
    logic [31:0] stride;
    logic [31:0] offset;
    logic [31:0] flags;
  } ctsv_snap_t;

  // one byte of reflected crc-32
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> rtl/ctsv_judge.sv
module ctsv_judge
  import ctsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [23:0]         max_frames,
  input  logic                snap_load,
  input  ctsv_snap_t          snap,
  output logic                snap_ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  // status, total_bytes, frame_total, sample_total, sample_start, computed_crc, zero pad
  output logic [RESULT_W-1:0] m_tdata
);

  ctsv_snap_t  held;
  logic        held_valid;
  logic        out_free;
  logic [3:0]  status;
  logic [31:0] remaining;
  logic [31:0] span;
  logic        offset_bad;

  assign out_free   = !m_tvalid || m_tready;
  assign snap_ready = !held_valid || out_free;

  // offset and sample count against the file size
  assign remaining  = held.size - held.offset;
  assign span       = held.offset + (held.count << SAMPLE_SHIFT);
  assign offset_bad = (held.offset < 32'(HEADER_BYTES)) || (held.offset > held.size) ||
                      (held.count > (remaining >> SAMPLE_SHIFT)) || (span != held.size);

  // ranked checks
  always_comb begin
    if (held.size < 32'(HEADER_BYTES)) begin
      status = ST_TRUNCATED;
    end else if (!held.magic_ok) begin
      status = ST_MAGIC;
    end else if (held.version_word[15:0] != VERSION_VAL) begin
      status = ST_VERSION;
    end else if (held.version_word[31:16] != 16'(HEADER_BYTES)) begin
      status = ST_HDR_SIZE;
    end else if (held.size_field != held.size) begin
      status = ST_TOTAL;
    end else if (held.crc_field != held.crc) begin
      status = ST_CRC;
    end else if (held.rate != RATE_VAL) begin
      status = ST_RATE;
    end else if (held.frames == 32'd0 || held.frames > {8'd0, max_frames}) begin
      status = ST_FRAMES;
    end else if (held.count != held.frames + 32'd1) begin
      status = ST_COUNT;
    end else if (held.stride != 32'(SAMPLE_BYTES)) begin
      status = ST_STRIDE;
    end else if (offset_bad) begin
      status = ST_OFFSET;
    end else if (held.flags != FLAGS_VAL) begin
      status = ST_FLAGS;
    end else if (held.sample_bad) begin
      status = ST_NONFINITE;
    end else begin
      status = ST_OK;
    end
  end

  // snapshot stage and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= held_valid;
      end
      if (snap_load) begin
        held_valid <= 1'b1;
      end else if (out_free) begin
        held_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      held <= snap;
    end
    if (out_free && held_valid) begin
      m_tdata <= {(RESULT_W - RESULT_BITS)'(0), held.crc, held.offset, held.count,
                  held.frames, held.size, status};
    end
  end

  // an ok verdict needs at least a full header
  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[STATUS_W-1:0] == ST_OK |->
      m_tdata[STATUS_W+31:STATUS_W] >= 32'(HEADER_BYTES))
    else $error("ok status with short file");

  // a new snapshot never lands on one that cannot move on
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    snap_load |-> snap_ready)
    else $error("snapshot overwritten");

  // a waiting snapshot is kept while the output stalls
  a_held_keep: assert property (@(posedge clk) disable iff (rst)
    held_valid && !out_free |=> held_valid)
    else $error("snapshot lost under stall");

endmodule

>>> rtl/camera_track_stream_validator.sv
// Byte-stream checker for camera track files. One byte is taken per clock on the s_ side;
// s_tlast marks the final byte of a file, and exactly one status transaction follows it on
// the m_ side, after the file's totals are captured into a snapshot register and the checks
// are ranked into the output register. The crc, header capture and sample checks all run
// at one byte per cycle, so a new file may begin on the cycle after the last byte of the
// previous one. s_tready drops only while a snapshot is waiting and the m_ side holds an
// earlier status unaccepted. max_frames is written through cfg_wr_en/cfg_wr_data and must
// only change between files.
module camera_track_stream_validator
  import ctsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [23:0]         cfg_wr_data,  // max_frames
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,      // data_byte
  input  logic                s_tlast,      // last_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  // status, total_bytes, frame_total, sample_total, sample_start, computed_crc, zero pad
  output logic [RESULT_W-1:0] m_tdata
);

  logic [23:0] max_frames;
  logic [31:0] byte_index, byte_index_next;
  logic [31:0] crc_reg, crc_next;
  logic        magic_ok, magic_ok_next;
  logic [31:0] header_words [HDR_WORDS];
  logic [31:0] hw_next [HDR_WORDS];
  logic [31:0] sample_word, sample_word_next;
  logic        sample_bad, sample_bad_next;
  logic        in_fire;
  logic        snap_ready;
  logic [7:0]  crc_in;
  logic [31:0] sample_diff;
  logic [SAMPLE_SHIFT-1:0] pos;
  logic        in_samples;
  ctsv_snap_t  snap;

  assign in_fire  = s_tvalid && s_tready;
  assign s_tready = snap_ready;

  // crc with the header crc field taken as zero
  assign crc_in   = (byte_index >= CRC_HOLE_LO && byte_index < CRC_HOLE_HI) ? 8'd0 : s_tdata;
  assign crc_next = crc32_byte(crc_reg, crc_in);

  // sample position relative to the header's sample offset
  assign in_samples  = (byte_index >= 32'(HEADER_BYTES)) && (byte_index >= 32'(HDR_CAPTURE)) &&
                       (byte_index >= header_words[OFFSET_WORD]);
  assign sample_diff = byte_index - header_words[OFFSET_WORD];
  assign pos         = sample_diff[SAMPLE_SHIFT-1:0];

  // per-byte state update
  always_comb begin
    hw_next          = header_words;
    magic_ok_next    = magic_ok;
    sample_word_next = sample_word;
    sample_bad_next  = sample_bad;
    byte_index_next  = (byte_index != INDEX_MAX) ? byte_index + 32'd1 : byte_index;

    if (byte_index < 32'd4 && s_tdata != MAGIC[byte_index[1:0]]) begin
      magic_ok_next = 1'b0;
    end

    if (byte_index < 32'(HDR_CAPTURE)) begin
      hw_next[byte_index[HDR_IDX_W+1:2]] = header_words[byte_index[HDR_IDX_W+1:2]] |
                                           ({24'd0, s_tdata} << {byte_index[1:0], 3'b000});
    end

    if (in_samples && 32'(pos) < 32'(CHECKED_BYTES)) begin
      sample_word_next = {s_tdata, sample_word[31:8]};
      if (pos[1:0] == 2'b11) begin
        if ((sample_word_next & EXP_MASK) == EXP_MASK) begin
          sample_bad_next = 1'b1;
        end
        if (32'(pos) == 32'(FOV_LAST_POS) &&
            (sample_word_next == 32'd0 || sample_word_next >= FOV_LIMIT)) begin
          sample_bad_next = 1'b1;
        end
      end
    end
  end

  // file state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frames  <= MAX_FRAMES_RST;
      byte_index  <= '0;
      crc_reg     <= CRC_INIT;
      magic_ok    <= 1'b1;
      sample_word <= '0;
      sample_bad  <= 1'b0;
      for (int k = 0; k < HDR_WORDS; k++) begin
        header_words[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        max_frames <= cfg_wr_data;
      end
      if (in_fire) begin
        if (s_tlast) begin
          byte_index  <= '0;
          crc_reg     <= CRC_INIT;
          magic_ok    <= 1'b1;
          sample_word <= '0;
          sample_bad  <= 1'b0;
          for (int k = 0; k < HDR_WORDS; k++) begin
            header_words[k] <= '0;
          end
        end else begin
          byte_index   <= byte_index_next;
          crc_reg      <= crc_next;
          magic_ok     <= magic_ok_next;
          sample_word  <= sample_word_next;
          sample_bad   <= sample_bad_next;
          header_words <= hw_next;
        end
      end
    end
  end

  // totals as they stand after the current byte
  always_comb begin
    snap.size         = byte_index_next;
    snap.crc          = ~crc_next;
    snap.magic_ok     = magic_ok_next;
    snap.sample_bad   = sample_bad_next;
    snap.version_word = hw_next[1];
    snap.size_field   = hw_next[2];
    snap.crc_field    = hw_next[3];
    snap.rate         = hw_next[4];
    snap.frames       = hw_next[5];
    snap.count        = hw_next[6];
    snap.stride       = hw_next[7];
    snap.offset       = hw_next[8];
    snap.flags        = hw_next[9];
  end

  ctsv_judge u_judge (
    .clk        (clk),
    .rst        (rst),
    .max_frames (max_frames),
    .snap_load  (in_fire && s_tlast),
    .snap       (snap),
    .snap_ready (snap_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // a last byte leaves the block ready for a fresh file
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tlast |=> byte_index == 32'd0 && crc_reg == CRC_INIT && magic_ok && !sample_bad)
    else $error("file state not cleared");

  // byte count steps by one until it saturates
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && !s_tlast && byte_index != INDEX_MAX |=> byte_index == $past(byte_index) + 32'd1)
    else $error("byte count slip");

  // a failed sample stays failed for the rest of the file
  a_bad_sticky: assert property (@(posedge clk) disable iff (rst)
    sample_bad && !(in_fire && s_tlast) |=> sample_bad)
    else $error("sample verdict dropped");

endmodule

>>> dv/camera_track_stream_validator_test.sv
`timescale 1ns / 100ps

module camera_track_stream_validator_test;
  import ctsv_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 400;

  // ways a generated track file can be spoilt
  typedef enum int {
    FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_HDR_SIZE, FLAW_TOTAL, FLAW_CRC, FLAW_RATE,
    FLAW_FRAMES_ZERO, FLAW_FRAMES_OVER, FLAW_FRAMES_AT_LIMIT, FLAW_COUNT, FLAW_STRIDE,
    FLAW_OFFSET, FLAW_FLAGS, FLAW_NONFINITE, FLAW_FOV_ZERO, FLAW_FOV_HIGH, FLAW_SHORT
  } flaw_t;

  typedef enum int {NOISE_RANDOM, NOISE_ZERO, NOISE_ONES, NOISE_MAGIC} noise_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } track_byte_t;

  // same bit order as m_tdata, status in the lowest bits
  typedef struct packed {
    logic [31:0] computed_crc;
    logic [31:0] sample_start;
    logic [31:0] sample_total;
    logic [31:0] frame_total;
    logic [31:0] total_bytes;
    logic [3:0]  status;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [23:0]         cfg_wr_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RESULT_W-1:0] m_tdata;

  // stimulus side
  track_byte_t byte_queue[$];
  track_byte_t next_byte;
  logic [23:0] cfg_setting = MAX_FRAMES_RST;
  logic [23:0] limit_plan[5];
  flaw_t       flaw_turn = FLAW_MAGIC;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned send_gap = 0;
  int unsigned ready_gap = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned phase_bytes, phase_files;
  int unsigned fail_count = 0;
  logic [15:0] status_seen = '0;

  // predictor state
  logic [23:0] frame_limit;
  logic [31:0] scan_index;
  logic [31:0] crc_run;
  logic        magic_good;
  logic [31:0] hdr_word[10];
  logic [31:0] float_acc;
  logic        float_fault;
  verdict_t    verdict_queue[$];

  camera_track_stream_validator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always #5 clk = ~clk;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // mostly no gap, some short, a few long; none at all when idling is off
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] finite_word();
    logic [31:0] w;
    w = $urandom;
    if ((w & EXP_MASK) == EXP_MASK) w[23] = 1'b0;
    return w;
  endfunction

  task automatic clear_scan();
    scan_index  = '0;
    crc_run     = CRC_INIT;
    magic_good  = 1'b1;
    foreach (hdr_word[k]) hdr_word[k] = '0;
    float_acc   = '0;
    float_fault = 1'b0;
  endtask

  // first failing check in file order
  function automatic logic [3:0] rank_checks(input logic [31:0] fsize, input logic [31:0] crc);
    logic [31:0] frames, count, off;
    frames = hdr_word[5];
    count  = hdr_word[6];
    off    = hdr_word[OFFSET_WORD];
    if (fsize < HEADER_BYTES) return ST_TRUNCATED;
    if (!magic_good) return ST_MAGIC;
    if (hdr_word[1][15:0] != VERSION_VAL) return ST_VERSION;
    if ({16'd0, hdr_word[1][31:16]} != HEADER_BYTES) return ST_HDR_SIZE;
    if (hdr_word[2] != fsize) return ST_TOTAL;
    if (hdr_word[3] != crc) return ST_CRC;
    if (hdr_word[4] != RATE_VAL) return ST_RATE;
    if (frames == 32'd0 || frames > {8'd0, frame_limit}) return ST_FRAMES;
    if (count != frames + 32'd1) return ST_COUNT;
    if (hdr_word[7] != SAMPLE_BYTES) return ST_STRIDE;
    if (off < HEADER_BYTES || off > fsize || count > (fsize - off) / SAMPLE_BYTES ||
        off + count * SAMPLE_BYTES != fsize) return ST_OFFSET;
    if (hdr_word[9] != FLAGS_VAL) return ST_FLAGS;
    if (float_fault) return ST_NONFINITE;
    return ST_OK;
  endfunction

  // advance the file state by one accepted byte
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [31:0] i, pos;
    verdict_t v;
    i = scan_index;
    crc_run = crc_next(crc_run, (i >= CRC_HOLE_LO && i < CRC_HOLE_HI) ? 8'h00 : b);
    if (i < 4 && b != MAGIC[i[1:0]]) magic_good = 1'b0;
    if (i < HDR_CAPTURE) hdr_word[i >> 2] = hdr_word[i >> 2] | ({24'd0, b} << (8 * i[1:0]));
    // samples only past the header and from the stated offset on
    if (i >= HEADER_BYTES && i >= HDR_CAPTURE && i >= hdr_word[OFFSET_WORD]) begin
      pos = (i - hdr_word[OFFSET_WORD]) % SAMPLE_BYTES;
      if (pos < CHECKED_BYTES) begin
        float_acc = {b, float_acc[31:8]};
        if (pos[1:0] == 2'd3) begin
          if ((float_acc & EXP_MASK) == EXP_MASK) float_fault = 1'b1;
          if (pos == FOV_LAST_POS && (float_acc == '0 || float_acc >= FOV_LIMIT))
            float_fault = 1'b1;
        end
      end
    end
    if (i != INDEX_MAX) scan_index = i + 32'd1;
    if (last) begin
      v.status       = rank_checks(scan_index, ~crc_run);
      v.total_bytes  = scan_index;
      v.frame_total  = hdr_word[5];
      v.sample_total = hdr_word[6];
      v.sample_start = hdr_word[OFFSET_WORD];
      v.computed_crc = ~crc_run;
      verdict_queue.push_back(v);
      clear_scan();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_verdict(input verdict_t got);
    verdict_t want;
    if (verdict_queue.size() == 0) begin
      $error("status transaction with no file pending, status %0d", got.status);
      fail_count++;
    end else begin
      want = verdict_queue.pop_front();
      status_seen[got.status] = 1'b1;
      check_field("status", want.status, got.status);
      check_field("total_bytes", want.total_bytes, got.total_bytes);
      check_field("frame_total", want.frame_total, got.frame_total);
      check_field("sample_total", want.sample_total, got.sample_total);
      check_field("sample_start", want.sample_start, got.sample_start);
      check_field("computed_crc", want.computed_crc, got.computed_crc);
    end
  endtask

  task automatic enqueue_file(input logic [7:0] img[$]);
    foreach (img[k]) byte_queue.push_back({img[k], k == img.size() - 1});
    bytes_sent += img.size();
    files_sent++;
  endtask

  task automatic queue_noise(input int unsigned len, input noise_t kind);
    logic [7:0] img[$];
    for (int k = 0; k < len; k++) begin
      case (kind)
        NOISE_ZERO:  img.push_back(8'h00);
        NOISE_ONES:  img.push_back(8'hFF);
        NOISE_MAGIC: img.push_back(k < 4 ? MAGIC[k % 4] : 8'($urandom));
        default:     img.push_back(8'($urandom));
      endcase
    end
    enqueue_file(img);
  endtask

  // well-formed track file with random content, then spoilt as asked
  task automatic queue_track(input flaw_t flaw, input int unsigned frames,
                             input int unsigned gap);
    logic [31:0] hw[10];
    logic [31:0] smp[8];
    logic [7:0]  img[$];
    logic [31:0] off, fsize, count, crc;
    int unsigned bad_sample, cut;
    bit          ff_fill;
    count = frames + 1;
    off   = HEADER_BYTES + gap;
    fsize = off + count * SAMPLE_BYTES;
    hw[0] = {MAGIC[3], MAGIC[2], MAGIC[1], MAGIC[0]};
    hw[1] = {16'(HEADER_BYTES), VERSION_VAL};
    hw[2] = fsize;
    hw[3] = '0;
    hw[4] = RATE_VAL;
    hw[5] = frames;
    hw[6] = count;
    hw[7] = SAMPLE_BYTES;
    hw[8] = off;
    hw[9] = FLAGS_VAL;
    // header faults
    case (flaw)
      FLAW_VERSION:     hw[1][15:0] = VERSION_VAL ^ 16'($urandom_range(1, 65535));
      FLAW_HDR_SIZE:    hw[1][31:16] = hw[1][31:16] ^ 16'($urandom_range(1, 65535));
      FLAW_TOTAL:       hw[2] = hw[2] ^ (32'd1 << $urandom_range(0, 31));
      FLAW_RATE:        hw[4] = hw[4] ^ (32'd1 << $urandom_range(0, 31));
      FLAW_FRAMES_ZERO: begin
        hw[5] = '0;
        hw[6] = 32'd1;
      end
      FLAW_FRAMES_OVER: begin
        hw[5] = ($urandom_range(0, 3) == 0) ? INDEX_MAX
                                            : {8'd0, cfg_setting} + $urandom_range(1, 4);
        hw[6] = hw[5] + 32'd1;
      end
      FLAW_FRAMES_AT_LIMIT: begin
        hw[5] = {8'd0, cfg_setting};
        hw[6] = hw[5] + 32'd1;
      end
      FLAW_COUNT:  hw[6] = hw[6] ^ (32'd1 << $urandom_range(0, 31));
      FLAW_STRIDE: hw[7] = hw[7] ^ (32'd1 << $urandom_range(0, 31));
      FLAW_OFFSET: begin
        case ($urandom_range(0, 3))
          0:       hw[8] = $urandom_range(0, HEADER_BYTES - 1);
          1:       hw[8] = fsize + $urandom_range(1, 64);
          2:       hw[8] = off + SAMPLE_BYTES;
          default: hw[8] = INDEX_MAX;
        endcase
      end
      FLAW_FLAGS: hw[9] = hw[9] ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    // header words, unused header bytes and the gap before the samples
    for (int k = 0; k < HDR_CAPTURE; k++) img.push_back(hw[k / 4][8 * (k % 4) +: 8]);
    ff_fill = $urandom_range(0, 1);
    for (int k = HDR_CAPTURE; k < off; k++) img.push_back(ff_fill ? 8'hFF : 8'($urandom));
    // samples: eight finite floats with the field of view in range
    bad_sample = $urandom_range(0, frames);
    for (int s = 0; s < count; s++) begin
      foreach (smp[w]) smp[w] = finite_word();
      case ($urandom_range(0, 3))
        0:       smp[6] = 32'd1;
        1:       smp[6] = FOV_LIMIT - 32'd1;
        default: smp[6] = $urandom_range(1, FOV_LIMIT - 1);
      endcase
      if (s == bad_sample) begin
        case (flaw)
          FLAW_NONFINITE: smp[$urandom_range(0, 7)] = {1'($urandom), 8'hFF, 23'($urandom)};
          FLAW_FOV_ZERO:  smp[6] = '0;
          FLAW_FOV_HIGH: begin
            case ($urandom_range(0, 3))
              0:       smp[6] = FOV_LIMIT;
              1:       smp[6] = FOV_LIMIT + $urandom_range(1, 32'h3CCB_FFFF);
              2:       smp[6] = {1'b1, 31'($urandom)};
              default: smp[6] = INDEX_MAX;
            endcase
          end
          default: ;
        endcase
      end
      foreach (smp[w]) for (int k = 0; k < 4; k++) img.push_back(smp[w][8 * k +: 8]);
    end
    if (flaw == FLAW_MAGIC) img[$urandom_range(0, 3)] ^= 8'd1 << $urandom_range(0, 7);
    // crc over the file with the crc field read as zero
    crc = CRC_INIT;
    foreach (img[k]) crc = crc_next(crc, (k >= CRC_HOLE_LO && k < CRC_HOLE_HI) ? 8'h00 : img[k]);
    crc = ~crc;
    if (flaw == FLAW_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) img[CRC_HOLE_LO + k] = crc[8 * k +: 8];
    if (flaw == FLAW_SHORT) begin
      cut = $urandom_range(1, img.size() - 1);
      while (img.size() > cut) img.delete(img.size() - 1);
    end
    enqueue_file(img);
  endtask

  // noise, clean files, and spoilt files that step through every fault in turn
  task automatic queue_random_file();
    int unsigned r, fmax, gap;
    r    = $urandom_range(0, 99);
    fmax = (cfg_setting < 3) ? cfg_setting : 3;
    gap  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    if (r < 10)
      queue_noise($urandom_range(1, 90), noise_t'($urandom_range(NOISE_RANDOM, NOISE_MAGIC)));
    else if (r < 15)
      queue_noise($urandom_range(1, HEADER_BYTES - 1), NOISE_RANDOM);
    else if (r < 30)
      queue_track(FLAW_NONE, $urandom_range(1, fmax), gap);
    else begin
      queue_track(flaw_turn, $urandom_range(1, fmax), gap);
      flaw_turn = (flaw_turn == FLAW_SHORT) ? FLAW_MAGIC : flaw_t'(int'(flaw_turn) + 1);
    end
  endtask

  // sender holds back until every status is back, then lets the block settle
  task automatic wait_idle();
    while (byte_queue.size() != 0 || s_tvalid || verdict_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_setting = v;
  endtask

  // byte driver, with the predictor fed from each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      frame_limit = MAX_FRAMES_RST;
      s_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) frame_limit = cfg_wr_data;
      if (s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          next_byte = byte_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_byte.data;
          s_tlast  <= next_byte.last;
          send_gap = idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // status monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_verdict(verdict_t'(m_tdata[RESULT_BITS-1:0]));
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (ready_gap != 0) begin
        ready_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        ready_gap = idle_len();
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles, %0d bytes queued, %0d statuses outstanding",
             quiet_cycles, byte_queue.size(), verdict_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    limit_plan = '{24'd1, 24'hFF_FFFF, 24'($urandom_range(3, 24'hFF_FFFE)), 24'd2,
                   MAX_FRAMES_RST};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: length boundaries, byte extremes, then a clean file with a gap
    queue_noise(1, NOISE_ZERO);
    queue_noise(1, NOISE_ONES);
    queue_noise(HEADER_BYTES - 1, NOISE_ZERO);
    queue_noise(HEADER_BYTES, NOISE_ONES);
    queue_noise(HDR_CAPTURE, NOISE_MAGIC);
    queue_track(FLAW_NONE, 2, 24);
    wait_idle();

    // random files under each max_frames setting
    foreach (limit_plan[p]) begin
      write_limit(limit_plan[p]);
      idle_on = !p[0];
      if (p == 1) begin
        // receiver stalls while a run of tiny files piles up behind it
        hold_req = 1'b1;
        repeat (24) queue_noise($urandom_range(1, 3), NOISE_RANDOM);
      end
      phase_bytes = bytes_sent;
      phase_files = files_sent;
      while (bytes_sent - phase_bytes < 160 || files_sent - phase_files < 2)
        queue_random_file();
      wait_idle();
    end

    $display("streamed %0d bytes in %0d files over %0d max_frames settings",
             bytes_sent, files_sent, $size(limit_plan) + 1);
    $display("status codes returned (bit n for code n): %b", status_seen[13:0]);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
